// File: src/mm_pkg.sv
// Shared constants for the matrix multiply block.
// No dependencies; compiled first.
package mm_pkg;

    localparam int OUT_WIDTH       = 34;  // signed Q18.16 result
    localparam int CFG_WIDTH       = 4;   // dimension registers
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int DEF_MAX_DIM     = 8;
    localparam int DEF_ELEM_WIDTH  = 16;

    localparam logic [CFG_WIDTH-1:0] DIM_RESET = 4'd8;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_A_ROW_COUNT = 2'd0,
        REG_INNER_SIZE  = 2'd1,
        REG_B_COL_COUNT = 2'd2
    } mm_reg_index_t;

endpackage

// File: src/mm_stream_if.sv
// Valid/ready request channels of the matrix multiply block.
// Depends on mm_pkg for the result width.
interface mm_elem_if #(
    parameter int ELEM_WIDTH = mm_pkg::DEF_ELEM_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mm_pkg::OUT_WIDTH-1:0]  product_value;
    logic                                 last_flag;

    modport source (output valid, output product_value, output last_flag, input ready);
    modport sink   (input valid, input product_value, input last_flag, output ready);
endinterface

// File: src/matrix_multiply.sv
// Fixed-point matrix multiply C = A * B. Send the elements of A (a_row_count x inner_size)
// and then of B (inner_size x b_col_count), row-major, one signed Q8.8 element per request.
// The request that completes B starts the product, which leaves row-major as signed Q18.16
// results, last_flag marking the final one; no new element is taken until every result has
// been handed over to the output register. All products go through a single
// multiply-accumulate unit fed from two element memories, one term per cycle; each result
// passes the memory read, multiply and accumulate stages, then the output register. A
// dimension register of zero counts as one and anything above MAX_DIM as MAX_DIM. Sums
// beyond the 34-bit range saturate. Registers must be written only between matrices or
// between elements of a load; the block itself does not enforce this.
module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = mm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [mm_pkg::CFG_WIDTH-1:0]          cfg_data,
    mm_elem_if.sink                               element,
    mm_result_if.source                           result
);
    import mm_pkg::*;

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int STORE_AW    = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int STORE_DEPTH = 2 ** STORE_AW;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int TOT_W       = 2 * DIM_W;
    localparam int PROD_W      = 2 * ELEM_WIDTH;
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int SAT_W       = (ACC_W > OUT_WIDTH) ? ACC_W : OUT_WIDTH;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'({1'b0, {(OUT_WIDTH-1){1'b1}}});
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        ST_LOAD,   // taking A then B
        ST_ISSUE,  // one term of the current dot product per cycle
        ST_DRAIN   // wait for the sum, then hand it to the output register
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] a_rows_reg, inner_reg, b_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_RESET;
            inner_reg  <= DIM_RESET;
            b_cols_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_A_ROW_COUNT: a_rows_reg <= cfg_data;
                REG_INNER_SIZE:  inner_reg  <= cfg_data;
                REG_B_COL_COUNT: b_cols_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // zero means one, above MAX_DIM means MAX_DIM
    logic [DIM_W-1:0] rows_c, inner_c, cols_c;

    always_comb
    begin
        if (a_rows_reg == '0)                    rows_c = DIM_W'(1);
        else if (a_rows_reg > CFG_WIDTH'(MAX_DIM)) rows_c = DIM_W'(MAX_DIM);
        else                                      rows_c = DIM_W'(a_rows_reg);
        if (inner_reg == '0)                     inner_c = DIM_W'(1);
        else if (inner_reg > CFG_WIDTH'(MAX_DIM))  inner_c = DIM_W'(MAX_DIM);
        else                                      inner_c = DIM_W'(inner_reg);
        if (b_cols_reg == '0)                    cols_c = DIM_W'(1);
        else if (b_cols_reg > CFG_WIDTH'(MAX_DIM)) cols_c = DIM_W'(MAX_DIM);
        else                                      cols_c = DIM_W'(b_cols_reg);
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic                loading_b_reg, loading_b_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DIM_W-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [STORE_AW-1:0] a_base_reg, a_base_next, a_addr_reg, a_addr_next;
    logic [STORE_AW-1:0] b_addr_reg, b_addr_next;
    logic                rd_vld_reg, rd_first_reg, rd_last_reg;
    logic                prod_vld_reg, prod_first_reg, prod_last_reg;
    logic                acc_done_reg, acc_done_next;
    logic                out_valid_reg, out_valid_next;

    logic                load_fire;
    logic                issue;
    logic                emit;
    logic [CNT_W-1:0]    count_inc;
    logic [TOT_W-1:0]    load_total;
    logic                last_elem;

    assign element.ready = (state_reg == ST_LOAD);
    assign load_fire     = element.valid && element.ready;
    assign issue         = (state_reg == ST_ISSUE);
    assign count_inc     = count_reg + 1'b1;
    assign load_total    = loading_b_reg ? TOT_W'(inner_c) * TOT_W'(cols_c)
                                         : TOT_W'(rows_c) * TOT_W'(inner_c);
    assign last_elem     = (i_reg == rows_c - 1'b1) && (j_reg == cols_c - 1'b1);
    // sum ready and the output register free (or emptied this cycle)
    assign emit          = (state_reg == ST_DRAIN) && acc_done_reg
                           && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        loading_b_next = loading_b_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        a_base_next    = a_base_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        acc_done_next  = acc_done_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
            out_valid_next = 1'b0;
        if (prod_vld_reg && prod_last_reg)
            acc_done_next = 1'b1;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    count_next = count_inc;
                    if (32'(count_inc) >= 32'(load_total))
                    begin
                        count_next     = '0;
                        loading_b_next = !loading_b_reg;
                        if (loading_b_reg)
                        begin
                            state_next  = ST_ISSUE;
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            a_base_next = '0;
                            a_addr_next = '0;
                            b_addr_next = '0;
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == inner_c - 1'b1)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next      = k_reg + 1'b1;
                    a_addr_next = a_addr_reg + 1'b1;
                    b_addr_next = b_addr_reg + STORE_AW'(cols_c);
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    acc_done_next  = 1'b0;
                    out_valid_next = 1'b1;
                    if (last_elem)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_ISSUE;
                    if (j_reg == cols_c - 1'b1)
                    begin
                        j_next      = '0;
                        i_next      = i_reg + 1'b1;
                        a_base_next = a_base_reg + STORE_AW'(inner_c);
                        a_addr_next = a_base_reg + STORE_AW'(inner_c);
                        b_addr_next = '0;
                    end
                    else
                    begin
                        j_next      = j_reg + 1'b1;
                        a_addr_next = a_base_reg;
                        b_addr_next = STORE_AW'(j_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            loading_b_reg  <= 1'b0;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            a_base_reg     <= '0;
            a_addr_reg     <= '0;
            b_addr_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            acc_done_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loading_b_reg  <= loading_b_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            a_base_reg     <= a_base_next;
            a_addr_reg     <= a_addr_next;
            b_addr_reg     <= b_addr_next;
            rd_vld_reg     <= issue;
            rd_first_reg   <= (k_reg == '0);
            rd_last_reg    <= (k_reg == inner_c - 1'b1);
            prod_vld_reg   <= rd_vld_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            acc_done_reg   <= acc_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Element memories, one write port (load) and one registered read
    // ------------------------------------------------------------------
    logic signed [ELEM_WIDTH-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_WIDTH-1:0] b_mem [STORE_DEPTH];
    logic signed [ELEM_WIDTH-1:0] a_rd_reg, b_rd_reg;

    always_ff @(posedge clk)
    begin
        if (load_fire && !loading_b_reg)
            a_mem[count_reg[STORE_AW-1:0]] <= element.element_value;
        if (load_fire && loading_b_reg)
            b_mem[count_reg[STORE_AW-1:0]] <= element.element_value;
        a_rd_reg <= a_mem[a_addr_reg];
        b_rd_reg <= b_mem[b_addr_reg];
    end

    // ------------------------------------------------------------------
    // Shared multiply-accumulate and output register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [SAT_W-1:0]     acc_ext;
    logic signed [OUT_WIDTH-1:0] sat_value;
    logic signed [OUT_WIDTH-1:0] out_value_reg;
    logic                        out_last_reg;

    assign acc_ext = SAT_W'(acc_reg);

    always_comb
    begin
        if (acc_ext > SAT_HI)      sat_value = SAT_HI[OUT_WIDTH-1:0];
        else if (acc_ext < SAT_LO) sat_value = SAT_LO[OUT_WIDTH-1:0];
        else                       sat_value = acc_ext[OUT_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
            prod_reg <= a_rd_reg * b_rd_reg;
        if (prod_vld_reg)
            acc_reg <= (prod_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        if (emit)
        begin
            out_value_reg <= sat_value;
            out_last_reg  <= last_elem;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.product_value = out_value_reg;
    assign result.last_flag     = out_last_reg;

endmodule
